[design/pdrs_pkg.sv]
// shared types, codes and default sizes for the priority dispatcher
// no dependencies; used by every design file and the checker
package pdrs_pkg;

  localparam int TAG_COUNT_DEF    = 64;
  localparam int QUEUE_DEPTH_DEF  = 16;
  localparam int ACTIVE_LIMIT_DEF = 16;
  localparam int NUM_CLASSES      = 3;
  localparam int RESERVED_URGENT  = 2;
  localparam int TAG_W            = 6;
  localparam int MAX_W            = 5;

  localparam logic [MAX_W-1:0] MAX_ACTIVE_RESET = 5'd6;

  localparam logic [1:0] CLS_LOW    = 2'd0;
  localparam logic [1:0] CLS_NORMAL = 2'd1;
  localparam logic [1:0] CLS_HIGH   = 2'd2;
  localparam logic [1:0] CLS_BAD    = 2'd3;

  typedef enum logic [1:0] {
    OP_SUBMIT = 2'd0,
    OP_FINISH = 2'd1,
    OP_CANCEL = 2'd2,
    OP_FLUSH  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    K_STARTED  = 2'd0,
    K_DROPPED  = 2'd1,
    K_FINISHED = 2'd2,
    K_REJECTED = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE      = 2'd0,
    ST_QUEUED    = 2'd1,
    ST_CANCELLED = 2'd2,
    ST_ACTIVE    = 2'd3
  } status_t;

  typedef struct packed {
    status_t    status;
    logic [1:0] cls;
  } tag_entry_t;

  typedef struct packed {
    kind_t            kind;
    logic [TAG_W-1:0] tag;
    logic [1:0]       cls;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVENT,
    S_FLUSH_RD,
    S_FLUSH_WR,
    S_PICK,
    S_POP_RD,
    S_POP_CHK,
    S_FINISH
  } state_t;

endpackage

[design/pdrs_tag_table.sv]
// per-tag status and class memory, one read and one write port, registered read
// valid flops make never-written entries read as idle; depends on pdrs_pkg
module pdrs_tag_table #(
  parameter int TAG_COUNT = pdrs_pkg::TAG_COUNT_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rd_en,
  input  logic [$clog2(TAG_COUNT)-1:0] rd_addr,
  output pdrs_pkg::tag_entry_t     rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(TAG_COUNT)-1:0] wr_addr,
  input  pdrs_pkg::tag_entry_t     wr_data
);

  pdrs_pkg::tag_entry_t mem [0:TAG_COUNT-1];
  logic [TAG_COUNT-1:0] valid;
  pdrs_pkg::tag_entry_t mem_q;
  logic                 valid_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        valid_q <= valid[rd_addr];
      end
    end
  end

  // an entry never written reads as idle
  always_comb begin
    rd_data = mem_q;
    if (!valid_q) begin
      rd_data.status = pdrs_pkg::ST_IDLE;
    end
  end

endmodule

[design/priority_dispatch_reserved_slots.sv]
// strict-priority dispatcher: three tag queues in one memory, tag table, sequencer
// states per event: event, pick, finish; a popped entry adds pop read, pop check, pick
// flush: scans every queue, read + write per drop; the last beat shows the cycle after finish
// throughput: one item at a time; busy drops after the finish cycle that follows an empty pick
// reset: synchronous rst clears queues, counters, tag valid bits; max_active returns to 6
// results cannot be stalled: each beat is shown for one cycle with result_valid
module priority_dispatch_reserved_slots #(
  parameter int TAG_COUNT    = pdrs_pkg::TAG_COUNT_DEF,
  parameter int QUEUE_DEPTH  = pdrs_pkg::QUEUE_DEPTH_DEF,
  parameter int ACTIVE_LIMIT = pdrs_pkg::ACTIVE_LIMIT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // command channel
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     opcode,
  input  logic [pdrs_pkg::TAG_W-1:0]     tag,
  input  logic [1:0]                     priority_req,
  // max_active register write
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pdrs_pkg::MAX_W-1:0]     cfg_data,
  // result beats
  output logic                           result_valid,
  output logic [1:0]                     result_kind,
  output logic [pdrs_pkg::TAG_W-1:0]     result_tag,
  output logic [1:0]                     result_priority,
  output logic                           last_result
);

  localparam int TIW = $clog2(TAG_COUNT);
  localparam int QIW = $clog2(QUEUE_DEPTH);
  localparam int QFW = $clog2(QUEUE_DEPTH + 1);
  localparam int QAW = QIW + 2;
  localparam int ACW = $clog2(ACTIVE_LIMIT + 1);
  localparam int LW  = (ACW > pdrs_pkg::MAX_W) ? ACW : pdrs_pkg::MAX_W;
  localparam int TW  = pdrs_pkg::TAG_W;

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  pdrs_pkg::state_t  state, state_next;
  pdrs_pkg::op_t     op;
  logic [TW-1:0]     cur_tag;
  logic [1:0]        cur_cls;
  logic [1:0]        flush_q;     // queue being drained by a flush
  logic [1:0]        pop_q;       // queue of the entry being started
  logic [pdrs_pkg::MAX_W-1:0] max_active;

  logic [QIW-1:0]    head [0:pdrs_pkg::NUM_CLASSES-1];
  logic [QFW-1:0]    fill [0:pdrs_pkg::NUM_CLASSES-1];
  logic [ACW-1:0]    active_total;
  logic [ACW-1:0]    nonurgent_active;

  // one result is held back so the final beat of an item can carry last_result
  pdrs_pkg::result_t pend;
  logic              pend_valid;

  // queue storage, address is {class, ring index}
  logic [TW-1:0]     qmem [0:(1 << QAW)-1];
  logic [TW-1:0]     qm_rdata;

  // ---------------------------------------------------------------------------
  // combinational controls
  // ---------------------------------------------------------------------------
  logic              accept;
  logic              tag_ok;
  logic [TIW-1:0]    cur_idx;

  logic              tt_rd_en;
  logic [TIW-1:0]    tt_rd_addr;
  pdrs_pkg::tag_entry_t tt_rd_data;
  logic              tt_wr_en;
  logic [TIW-1:0]    tt_wr_addr;
  pdrs_pkg::tag_entry_t tt_wr_data;

  logic              qm_rd_en;
  logic [QAW-1:0]    qm_rd_addr;
  logic              qm_wr_en;
  logic [QAW-1:0]    qm_wr_addr;

  logic              push_en;
  logic              pop_en;
  logic [1:0]        pop_sel;
  logic              act_inc, act_dec, nu_inc, nu_dec;
  logic              flush_adv;

  logic              emit;
  pdrs_pkg::result_t emit_res;

  logic [LW-1:0]     lim, rsv, thresh;
  logic              pick_any;
  logic [1:0]        pick_sel;
  logic              queue_full;
  logic [QIW:0]      tail_sum;
  logic [QIW-1:0]    tail;

  assign accept    = start && !busy;
  assign busy      = (state != pdrs_pkg::S_IDLE);
  assign cfg_ready = !busy;
  assign tag_ok    = ({3'b000, cur_tag} < 9'(TAG_COUNT));
  assign cur_idx   = TIW'(cur_tag);

  // effective slot limit, clamped to 1..ACTIVE_LIMIT, and the share open to non-high work
  always_comb begin
    if (max_active == '0) begin
      lim = LW'(1);
    end else if (LW'(max_active) > LW'(ACTIVE_LIMIT)) begin
      lim = LW'(ACTIVE_LIMIT);
    end else begin
      lim = LW'(max_active);
    end
    rsv    = ((lim - LW'(1)) < LW'(pdrs_pkg::RESERVED_URGENT)) ?
             (lim - LW'(1)) : LW'(pdrs_pkg::RESERVED_URGENT);
    thresh = lim - rsv;
  end

  // which queue to start from next: high first, then normal, then low
  always_comb begin
    pick_any = 1'b0;
    pick_sel = pdrs_pkg::CLS_LOW;
    if (LW'(active_total) < lim) begin
      if (fill[pdrs_pkg::CLS_HIGH] != '0) begin
        pick_any = 1'b1;
        pick_sel = pdrs_pkg::CLS_HIGH;
      end else if (LW'(nonurgent_active) < thresh) begin
        if (fill[pdrs_pkg::CLS_NORMAL] != '0) begin
          pick_any = 1'b1;
          pick_sel = pdrs_pkg::CLS_NORMAL;
        end else if (fill[pdrs_pkg::CLS_LOW] != '0) begin
          pick_any = 1'b1;
          pick_sel = pdrs_pkg::CLS_LOW;
        end
      end
    end
  end

  // push slot of the submitted class; head + fill stays below twice the depth
  assign queue_full = (fill[cur_cls] == QFW'(QUEUE_DEPTH));
  assign tail_sum   = {1'b0, head[cur_cls]} + (QIW+1)'(fill[cur_cls]);
  assign tail       = (tail_sum >= (QIW+1)'(QUEUE_DEPTH)) ?
                      QIW'(tail_sum - (QIW+1)'(QUEUE_DEPTH)) : QIW'(tail_sum);

  // ---------------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      pdrs_pkg::S_IDLE: begin
        if (accept) begin
          state_next = pdrs_pkg::S_EVENT;
        end
      end
      pdrs_pkg::S_EVENT: begin
        if (op == pdrs_pkg::OP_FLUSH) begin
          state_next = pdrs_pkg::S_FLUSH_RD;
        end else begin
          state_next = pdrs_pkg::S_PICK;
        end
      end
      pdrs_pkg::S_FLUSH_RD: begin
        if (fill[flush_q] != '0) begin
          state_next = pdrs_pkg::S_FLUSH_WR;
        end else if (flush_q == pdrs_pkg::CLS_HIGH) begin
          state_next = pdrs_pkg::S_PICK;
        end
      end
      pdrs_pkg::S_FLUSH_WR: state_next = pdrs_pkg::S_FLUSH_RD;
      pdrs_pkg::S_PICK: begin
        if (pick_any) begin
          state_next = pdrs_pkg::S_POP_RD;
        end else begin
          state_next = pdrs_pkg::S_FINISH;
        end
      end
      pdrs_pkg::S_POP_RD:  state_next = pdrs_pkg::S_POP_CHK;
      pdrs_pkg::S_POP_CHK: state_next = pdrs_pkg::S_PICK;
      pdrs_pkg::S_FINISH:  state_next = pdrs_pkg::S_IDLE;
      default:             state_next = pdrs_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // per-state actions: memory requests, counter steps and result beats
  // every access to a tag or queue entry finishes before the next one starts, in order,
  // so no two accesses to the same entry overlap
  // ---------------------------------------------------------------------------
  always_comb begin
    tt_rd_en   = 1'b0;
    tt_rd_addr = TIW'(tag);
    tt_wr_en   = 1'b0;
    tt_wr_addr = cur_idx;
    tt_wr_data = tt_rd_data;
    qm_rd_en   = 1'b0;
    qm_rd_addr = {pick_sel, head[pick_sel]};
    qm_wr_en   = 1'b0;
    qm_wr_addr = {cur_cls, tail};
    push_en    = 1'b0;
    pop_en     = 1'b0;
    pop_sel    = pick_sel;
    act_inc    = 1'b0;
    act_dec    = 1'b0;
    nu_inc     = 1'b0;
    nu_dec     = 1'b0;
    flush_adv  = 1'b0;
    emit       = 1'b0;
    emit_res   = '{kind: pdrs_pkg::K_REJECTED, tag: cur_tag, cls: cur_cls};
    case (state)
      pdrs_pkg::S_IDLE: begin
        tt_rd_en = accept;
      end
      pdrs_pkg::S_EVENT: begin
        case (op)
          pdrs_pkg::OP_SUBMIT: begin
            if (!tag_ok || tt_rd_data.status != pdrs_pkg::ST_IDLE || queue_full) begin
              emit = 1'b1;
            end else begin
              qm_wr_en   = 1'b1;
              push_en    = 1'b1;
              tt_wr_en   = 1'b1;
              tt_wr_data = '{status: pdrs_pkg::ST_QUEUED, cls: cur_cls};
            end
          end
          pdrs_pkg::OP_FINISH: begin
            if (tag_ok && tt_rd_data.status == pdrs_pkg::ST_ACTIVE) begin
              tt_wr_en          = 1'b1;
              tt_wr_data.status = pdrs_pkg::ST_IDLE;
              act_dec           = 1'b1;
              nu_dec            = (tt_rd_data.cls != pdrs_pkg::CLS_HIGH);
              emit              = 1'b1;
              emit_res          = '{kind: pdrs_pkg::K_FINISHED, tag: cur_tag,
                                    cls: tt_rd_data.cls};
            end
          end
          pdrs_pkg::OP_CANCEL: begin
            if (tag_ok && tt_rd_data.status == pdrs_pkg::ST_QUEUED) begin
              tt_wr_en          = 1'b1;
              tt_wr_data.status = pdrs_pkg::ST_CANCELLED;
            end else if (tag_ok && tt_rd_data.status == pdrs_pkg::ST_ACTIVE) begin
              // slot freed at once, no beat
              tt_wr_en          = 1'b1;
              tt_wr_data.status = pdrs_pkg::ST_IDLE;
              act_dec           = 1'b1;
              nu_dec            = (tt_rd_data.cls != pdrs_pkg::CLS_HIGH);
            end
          end
          default: begin
          end
        endcase
      end
      pdrs_pkg::S_FLUSH_RD: begin
        qm_rd_addr = {flush_q, head[flush_q]};
        pop_sel    = flush_q;
        if (fill[flush_q] != '0) begin
          qm_rd_en = 1'b1;
          pop_en   = 1'b1;
        end else begin
          flush_adv = (flush_q != pdrs_pkg::CLS_HIGH);
        end
      end
      pdrs_pkg::S_FLUSH_WR: begin
        // cancelled entries are reported as dropped too
        tt_wr_en   = 1'b1;
        tt_wr_addr = TIW'(qm_rdata);
        tt_wr_data = '{status: pdrs_pkg::ST_IDLE, cls: flush_q};
        emit       = 1'b1;
        emit_res   = '{kind: pdrs_pkg::K_DROPPED, tag: qm_rdata, cls: flush_q};
      end
      pdrs_pkg::S_PICK: begin
        if (pick_any) begin
          qm_rd_en = 1'b1;
          pop_en   = 1'b1;
        end
      end
      pdrs_pkg::S_POP_RD: begin
        tt_rd_en   = 1'b1;
        tt_rd_addr = TIW'(qm_rdata);
      end
      pdrs_pkg::S_POP_CHK: begin
        tt_wr_en   = 1'b1;
        tt_wr_addr = TIW'(qm_rdata);
        if (tt_rd_data.status == pdrs_pkg::ST_QUEUED) begin
          tt_wr_data.status = pdrs_pkg::ST_ACTIVE;
          act_inc           = 1'b1;
          nu_inc            = (pop_q != pdrs_pkg::CLS_HIGH);
          emit              = 1'b1;
          emit_res          = '{kind: pdrs_pkg::K_STARTED, tag: qm_rdata, cls: pop_q};
        end else begin
          // cancelled while queued: dropped silently
          tt_wr_data.status = pdrs_pkg::ST_IDLE;
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // tag table
  // ---------------------------------------------------------------------------
  pdrs_tag_table #(
    .TAG_COUNT (TAG_COUNT)
  ) u_tag_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (tt_rd_en),
    .rd_addr (tt_rd_addr),
    .rd_data (tt_rd_data),
    .wr_en   (tt_wr_en),
    .wr_addr (tt_wr_addr),
    .wr_data (tt_wr_data)
  );

  // ---------------------------------------------------------------------------
  // queue memory
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (qm_wr_en) begin
      qmem[qm_wr_addr] <= cur_tag;
    end
    if (qm_rd_en) begin
      qm_rdata <= qmem[qm_rd_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // control and counter registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= pdrs_pkg::S_IDLE;
      max_active       <= pdrs_pkg::MAX_ACTIVE_RESET;
      active_total     <= '0;
      nonurgent_active <= '0;
      flush_q          <= pdrs_pkg::CLS_LOW;
      for (int i = 0; i < pdrs_pkg::NUM_CLASSES; i++) begin
        head[i] <= '0;
        fill[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        max_active <= cfg_data;
      end
      if (accept) begin
        flush_q <= pdrs_pkg::CLS_LOW;
      end else if (flush_adv) begin
        flush_q <= flush_q + 2'd1;
      end
      if (push_en) begin
        fill[cur_cls] <= fill[cur_cls] + QFW'(1);
      end
      if (pop_en) begin
        fill[pop_sel] <= fill[pop_sel] - QFW'(1);
        head[pop_sel] <= (head[pop_sel] == QIW'(QUEUE_DEPTH - 1)) ?
                         '0 : head[pop_sel] + QIW'(1);
      end
      if (act_inc) begin
        active_total <= active_total + ACW'(1);
      end else if (act_dec && active_total != '0) begin
        active_total <= active_total - ACW'(1);
      end
      if (nu_inc) begin
        nonurgent_active <= nonurgent_active + ACW'(1);
      end else if (nu_dec && nonurgent_active != '0) begin
        nonurgent_active <= nonurgent_active - ACW'(1);
      end
    end
  end

  // latched command fields; priority three counts as high
  always_ff @(posedge clk) begin
    if (accept) begin
      op      <= pdrs_pkg::op_t'(opcode);
      cur_tag <= tag;
      cur_cls <= (priority_req == pdrs_pkg::CLS_BAD) ? pdrs_pkg::CLS_HIGH : priority_req;
    end
    if (state == pdrs_pkg::S_PICK) begin
      pop_q <= pick_sel;
    end
  end

  // ---------------------------------------------------------------------------
  // result beats: each new result pushes out the held one; the held one
  // leaves with last_result set when the item finishes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      pend_valid   <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (emit) begin
        pend       <= emit_res;
        pend_valid <= 1'b1;
        if (pend_valid) begin
          result_valid    <= 1'b1;
          result_kind     <= pend.kind;
          result_tag      <= pend.tag;
          result_priority <= pend.cls;
          last_result     <= 1'b0;
        end
      end else if (state == pdrs_pkg::S_FINISH && pend_valid) begin
        pend_valid      <= 1'b0;
        result_valid    <= 1'b1;
        result_kind     <= pend.kind;
        result_tag      <= pend.tag;
        result_priority <= pend.cls;
        last_result     <= 1'b1;
      end
    end
  end

endmodule

[design/pdrs_checker.sv]
// port-level checks for the priority dispatcher, bound to the top level
// depends on pdrs_pkg and priority_dispatch_reserved_slots
module pdrs_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       result_valid,
  input logic [1:0]                 result_priority,
  input logic                       last_result
);

  // an accepted command raises busy in the next cycle
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  // beats other than the final one only appear while the item is in work
  a_mid_beat_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_result |-> busy)
    else $error("non-final beat outside of a command");

  // the final beat arrives after the block has gone idle, and nothing follows at once
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_result |-> !busy)
    else $error("final beat while still busy");

  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_result |=> !result_valid)
    else $error("beat directly after a final beat");

  a_class_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result_priority != pdrs_pkg::CLS_BAD)
    else $error("result class out of range");

endmodule

bind priority_dispatch_reserved_slots pdrs_checker u_pdrs_checker (
  .clk             (clk),
  .rst             (rst),
  .start           (start),
  .busy            (busy),
  .result_valid    (result_valid),
  .result_priority (result_priority),
  .last_result     (last_result)
);

[tb/tb_priority_dispatch_reserved_slots.sv]
// self-checking bench for the strict-priority dispatcher with reserved urgent slots
// drives events over start/busy, predicts every result beat and compares them in order
// depends on pdrs_pkg and priority_dispatch_reserved_slots
module tb_priority_dispatch_reserved_slots;
  timeunit 1ns;
  timeprecision 1ps;
  import pdrs_pkg::*;

  localparam int NTAGS         = TAG_COUNT_DEF;
  localparam int QDEPTH        = QUEUE_DEPTH_DEF;
  localparam int SLOT_CAP      = ACTIVE_LIMIT_DEF;
  // worst quiet stretch of a correct run: a pop loop skipping 48 cancelled
  // entries, plus the longest sender gap
  localparam int STALL_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_BOUND   = 2000;

  // one expected result beat
  typedef struct {
    kind_t            kind;
    logic [TAG_W-1:0] tag;
    logic [1:0]       cls;
    logic             last;
  } beat_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic [1:0]       opcode = OP_SUBMIT;
  logic [TAG_W-1:0] tag = '0;
  logic [1:0]       priority_req = CLS_LOW;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [MAX_W-1:0] cfg_data = '0;
  logic             result_valid;
  logic [1:0]       result_kind;
  logic [TAG_W-1:0] result_tag;
  logic [1:0]       result_priority;
  logic             last_result;

  priority_dispatch_reserved_slots DUT (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .opcode          (opcode),
    .tag             (tag),
    .priority_req    (priority_req),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .result_valid    (result_valid),
    .result_kind     (result_kind),
    .result_tag      (result_tag),
    .result_priority (result_priority),
    .last_result     (last_result)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // dispatcher model: tag table, three ring queues, slot counters
  // ---------------------------------------------------------------------------
  status_t          tag_state [NTAGS];
  logic [1:0]       tag_cls   [NTAGS];
  logic [TAG_W-1:0] lane_mem  [NUM_CLASSES][QDEPTH];
  int unsigned      lane_head [NUM_CLASSES];
  int unsigned      lane_fill [NUM_CLASSES];
  int unsigned      busy_slots;
  int unsigned      nonurgent_slots;
  logic [MAX_W-1:0] max_setting;

  beat_t            event_beats[$];    // beats of the event being modeled
  beat_t            awaited_beats[$];  // beats predicted but not yet seen

  int unsigned      items_sent;
  int unsigned      beats_checked;
  int unsigned      cfg_writes;
  int unsigned      mismatches;

  function automatic void model_reset();
    foreach (tag_state[i]) begin
      tag_state[i] = ST_IDLE;
      tag_cls[i]   = CLS_LOW;
    end
    for (int q = 0; q < NUM_CLASSES; q++) begin
      lane_head[q] = 0;
      lane_fill[q] = 0;
    end
    busy_slots      = 0;
    nonurgent_slots = 0;
    max_setting     = MAX_ACTIVE_RESET;
  endfunction

  function automatic void note_beat(kind_t k, logic [TAG_W-1:0] t, logic [1:0] c);
    beat_t b;
    b.kind = k;
    b.tag  = t;
    b.cls  = c;
    b.last = 1'b0;
    event_beats.insert(event_beats.size(), b);
  endfunction

  function automatic logic [TAG_W-1:0] lane_pop(int unsigned q);
    logic [TAG_W-1:0] t;
    t = lane_mem[q][lane_head[q]];
    lane_head[q] = (lane_head[q] + 1) % QDEPTH;
    lane_fill[q]--;
    return t;
  endfunction

  function automatic void release_slot(logic [TAG_W-1:0] t);
    tag_state[t] = ST_IDLE;
    if (busy_slots > 0) busy_slots--;
    if (tag_cls[t] != CLS_HIGH && nonurgent_slots > 0) nonurgent_slots--;
  endfunction

  // start queued work until slots, the non-high share or queues run out
  function automatic void fill_free_slots();
    int unsigned      lim;
    int unsigned      reserve;
    int unsigned      q;
    logic [TAG_W-1:0] t;
    lim = (max_setting == 0) ? 1 : ((max_setting > SLOT_CAP) ? SLOT_CAP : max_setting);
    reserve = (lim - 1 < RESERVED_URGENT) ? lim - 1 : RESERVED_URGENT;
    while (busy_slots < lim) begin
      // high ignores the reserve, the others stop short of it
      if (lane_fill[CLS_HIGH] != 0) q = CLS_HIGH;
      else if (nonurgent_slots >= lim - reserve) return;
      else if (lane_fill[CLS_NORMAL] != 0) q = CLS_NORMAL;
      else if (lane_fill[CLS_LOW] != 0) q = CLS_LOW;
      else return;
      t = lane_pop(q);
      if (tag_state[t] != ST_QUEUED) begin
        // cancelled while waiting: dropped with no beat
        tag_state[t] = ST_IDLE;
        continue;
      end
      tag_state[t] = ST_ACTIVE;
      busy_slots++;
      if (q != CLS_HIGH) nonurgent_slots++;
      note_beat(K_STARTED, t, 2'(q));
    end
  endfunction

  // work out the beats one accepted event causes and queue them up
  function automatic void compute_dispatch_beats(op_t op, logic [TAG_W-1:0] t,
                                                 logic [1:0] p);
    logic [1:0]       c;
    logic [TAG_W-1:0] d;
    event_beats.delete();
    c = (p > CLS_HIGH) ? CLS_HIGH : p;
    case (op)
      OP_SUBMIT: begin
        if (tag_state[t] != ST_IDLE || lane_fill[c] >= QDEPTH) begin
          note_beat(K_REJECTED, t, c);
        end else begin
          lane_mem[c][(lane_head[c] + lane_fill[c]) % QDEPTH] = t;
          lane_fill[c]++;
          tag_state[t] = ST_QUEUED;
          tag_cls[t]   = c;
        end
      end
      OP_FINISH: begin
        if (tag_state[t] == ST_ACTIVE) begin
          release_slot(t);
          note_beat(K_FINISHED, t, tag_cls[t]);
        end
      end
      OP_CANCEL: begin
        if (tag_state[t] == ST_QUEUED) tag_state[t] = ST_CANCELLED;
        else if (tag_state[t] == ST_ACTIVE) release_slot(t);
      end
      default: begin
        // flush: low, normal, high, each oldest first, cancelled ones too
        for (int q = 0; q < NUM_CLASSES; q++) begin
          while (lane_fill[q] != 0) begin
            d = lane_pop(q);
            tag_state[d] = ST_IDLE;
            note_beat(K_DROPPED, d, 2'(q));
          end
        end
      end
    endcase
    fill_free_slots();
    if (event_beats.size() != 0) event_beats[event_beats.size() - 1].last = 1'b1;
    foreach (event_beats[i]) awaited_beats.insert(awaited_beats.size(), event_beats[i]);
  endfunction

  // random tag in the wanted state, any tag when none is
  function automatic logic [TAG_W-1:0] pick_tag(status_t want);
    int unsigned base;
    logic [TAG_W-1:0] t;
    base = $urandom_range(0, NTAGS - 1);
    for (int i = 0; i < NTAGS; i++) begin
      t = TAG_W'((base + i) % NTAGS);
      if (tag_state[t] == want) return t;
    end
    return TAG_W'($urandom_range(0, NTAGS - 1));
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin : beat_check
    beat_t want;
    if (!rst && result_valid) begin
      beats_checked++;
      if (awaited_beats.size() == 0) begin
        flag_mismatch($sformatf("unexpected beat kind %0d tag %0d class %0d",
                                result_kind, result_tag, result_priority));
      end else begin
        want = awaited_beats[0];
        awaited_beats.delete(0);
        if (result_kind !== want.kind)
          flag_mismatch($sformatf("tag %0d kind %0d, want %0d", want.tag, result_kind,
                                  want.kind));
        if (result_tag !== want.tag)
          flag_mismatch($sformatf("tag %0d, want %0d", result_tag, want.tag));
        if (result_priority !== want.cls)
          flag_mismatch($sformatf("tag %0d class %0d, want %0d", want.tag,
                                  result_priority, want.cls));
        if (last_result !== want.last)
          flag_mismatch($sformatf("tag %0d last %0b, want %0b", want.tag, last_result,
                                  want.last));
      end
    end
  end

  // watchdog: nothing moving on any channel for too long ends the run
  int unsigned stall_count = 0;
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
      stall_count <= 0;
    else
      stall_count <= stall_count + 1;
    if (stall_count == STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sender side; every task starts and ends at a falling edge
  // ---------------------------------------------------------------------------

  // start is left high so back-to-back events need no new edge on it
  task automatic send_event(op_t op, logic [TAG_W-1:0] t, logic [1:0] p);
    start        <= 1'b1;
    opcode       <= op;
    tag          <= t;
    priority_req <= p;
    do @(posedge clk); while (busy);
    compute_dispatch_beats(op, t, p);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drop_start();
    if (start) start <= 1'b0;
  endtask

  task automatic hold_sender(int unsigned cycles);
    drop_start();
    repeat (cycles) @(negedge clk);
  endtask

  // sender waits until every predicted beat is back and the block is idle
  task automatic wait_quiet();
    drop_start();
    @(negedge clk);
    while (awaited_beats.size() != 0 || busy) @(negedge clk);
    // ignored events leave no beat but may still keep the sequencer going
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_max_active(logic [MAX_W-1:0] v);
    wait_quiet();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    max_setting = v;
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly well-formed traffic: submits of idle tags, finishes of running
  // ones, cancels of queued or running ones, rare flushes, some raw noise
  task automatic run_traffic(int unsigned n, int unsigned finish_pct,
                             int unsigned max_gap);
    int unsigned      burst;
    int unsigned      bursts_done;
    int unsigned      pick;
    op_t              op;
    logic [TAG_W-1:0] t;
    logic [1:0]       p;
    burst = $urandom_range(1, 12);
    bursts_done = 0;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      p = 2'($urandom_range(0, 3));
      if (pick < 8) begin
        op = op_t'($urandom_range(0, 3));
        t  = TAG_W'($urandom_range(0, NTAGS - 1));
      end else if (pick < 8 + finish_pct) begin
        op = OP_FINISH;
        t  = pick_tag(ST_ACTIVE);
      end else if (pick < 18 + finish_pct) begin
        op = OP_CANCEL;
        t  = $urandom_range(0, 1) ? pick_tag(ST_QUEUED) : pick_tag(ST_ACTIVE);
      end else if (pick < 21 + finish_pct) begin
        op = OP_FLUSH;
        t  = TAG_W'($urandom_range(0, NTAGS - 1));
      end else begin
        op = OP_SUBMIT;
        t  = ($urandom_range(0, 9) == 0) ? TAG_W'($urandom_range(0, NTAGS - 1))
                                        : pick_tag(ST_IDLE);
      end
      send_event(op, t, p);
      burst--;
      if (burst == 0) begin
        bursts_done++;
        if (bursts_done % 8 == 0) wait_quiet();
        else if (max_gap != 0) hold_sender($urandom_range(1, max_gap));
        burst = $urandom_range(1, 12);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // hand-picked events at the reset limit of six slots, two kept for high
  task automatic test_directed_events();
    send_event(OP_SUBMIT, 6'd0,  CLS_LOW);     // empty block starts it at once
    send_event(OP_SUBMIT, 6'd63, CLS_BAD);     // class three runs as high
    send_event(OP_SUBMIT, 6'd63, CLS_NORMAL);  // tag already in service
    send_event(OP_FINISH, 6'd0,  CLS_HIGH);
    send_event(OP_FINISH, 6'd0,  CLS_LOW);     // no longer in service
    send_event(OP_CANCEL, 6'd63, CLS_LOW);     // running tag, slot freed quietly
    send_event(OP_CANCEL, 6'd12, CLS_LOW);     // idle tag
    for (int i = 1; i <= 4; i++) send_event(OP_SUBMIT, TAG_W'(i), CLS_NORMAL);
    send_event(OP_SUBMIT, 6'd5,  CLS_LOW);     // held back by the urgent reserve
    send_event(OP_SUBMIT, 6'd6,  CLS_NORMAL);
    send_event(OP_SUBMIT, 6'd7,  CLS_HIGH);    // high may take reserved slots
    send_event(OP_SUBMIT, 6'd8,  CLS_HIGH);
    send_event(OP_CANCEL, 6'd6,  CLS_LOW);     // queued tag marked
    send_event(OP_CANCEL, 6'd6,  CLS_LOW);     // already cancelled
    send_event(OP_FINISH, 6'd1,  CLS_LOW);     // skips cancelled normal, starts low
    send_event(OP_SUBMIT, 6'd9,  CLS_LOW);
    send_event(OP_SUBMIT, 6'd10, CLS_NORMAL);
    send_event(OP_SUBMIT, 6'd11, CLS_HIGH);    // every slot taken, high waits
    send_event(OP_CANCEL, 6'd10, CLS_LOW);
    send_event(OP_FLUSH,  6'd63, CLS_BAD);     // low, normal, high in order
  endtask

  // one slot with work in service: every queue fills up, overflows, then one
  // flush reports all 48 entries
  task automatic test_full_queues();
    write_max_active(5'd1);
    for (int c = 0; c < NUM_CLASSES; c++) begin
      repeat (QDEPTH) send_event(OP_SUBMIT, pick_tag(ST_IDLE), 2'(c));
      send_event(OP_SUBMIT, pick_tag(ST_IDLE), 2'(c));  // queue full
    end
    send_event(OP_CANCEL, pick_tag(ST_QUEUED), CLS_LOW);
    send_event(OP_FLUSH, pick_tag(ST_ACTIVE), CLS_NORMAL);
  endtask

  // random traffic under a range of limits, zero and all-ones among them;
  // dropping from 31 to 2 can leave more in service than the new limit
  task automatic test_limit_sweep();
    write_max_active(5'd1);  run_traffic(40, 35, 6);
    write_max_active(5'd16); run_traffic(45, 20, 0);
    write_max_active(5'd0);  run_traffic(35, 35, 10);
    write_max_active(5'd31); run_traffic(45, 15, 4);
    write_max_active(5'd2);  run_traffic(40, 30, 8);
    write_max_active(5'd3);  run_traffic(40, 25, 3);
    write_max_active(5'd17); run_traffic(35, 20, 5);
    write_max_active(MAX_ACTIVE_RESET); run_traffic(40, 25, 30);
  endtask

  initial begin
    items_sent    = 0;
    beats_checked = 0;
    cfg_writes    = 0;
    mismatches    = 0;
    model_reset();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_events();
    test_full_queues();
    test_limit_sweep();

    // final drain, bounded; anything still awaited afterwards is a miss
    drop_start();
    @(negedge clk);
    for (int n = 0; n < DRAIN_BOUND && (awaited_beats.size() != 0 || busy); n++)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (awaited_beats.size() != 0)
      flag_mismatch($sformatf("%0d beats never arrived", awaited_beats.size()));

    $display("run: %0d events, %0d result beats checked, %0d limit writes",
             items_sent, beats_checked, cfg_writes);
    $display("run: saturated queues, cancel skips, flushes, limits from 0 to 31");
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
